// File: hw/rtl/ttu_pkg.sv
// Shared types and constants of the triangle tangent unit.
`timescale 1ns / 1ps

package ttu_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int MAG_W   = PROD_W;
  localparam int FRAC_W  = 16;
  localparam int DIVD_W  = MAG_W + FRAC_W;
  localparam int QUO_W   = COORD_W + 1;
  localparam int DSH_W   = MAG_W + QUO_W - 1;
  localparam int WIDE_W  = MAG_W + QUO_W;
  localparam int AXES    = 3;

  localparam int MUL_STEPS = 8;
  localparam int STEP_W    = $clog2(MUL_STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MUL_STEPS - 1);

  localparam int CNT_W = $clog2(QUO_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

  localparam logic [COORD_W-1:0] SAT_POS     = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] SAT_NEG     = 32'h8000_0000;
  localparam logic [QUO_W-1:0]   QUO_POS_MAX = 33'h0_7FFF_FFFF;
  localparam logic [QUO_W-1:0]   QUO_NEG_MAX = 33'h0_8000_0000;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] tex_u;
    logic signed [COORD_W-1:0] tex_v;
  } vertex_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] tangent_x;
    logic signed [COORD_W-1:0] tangent_y;
    logic signed [COORD_W-1:0] tangent_z;
    logic                      degenerate;
    logic                      saturated;
  } tangent_t;

  // Edge differences of one triangle, each an exact two's complement value.
  typedef struct packed {
    logic [AXES-1:0][DIFF_W-1:0] da1;
    logic [AXES-1:0][DIFF_W-1:0] da2;
    logic [DIFF_W-1:0]           du1;
    logic [DIFF_W-1:0]           dv1;
    logic [DIFF_W-1:0]           du2;
    logic [DIFF_W-1:0]           dv2;
  } diff_t;

  typedef enum logic [1:0] {
    CORNER_0,
    CORNER_1,
    CORNER_2
  } phase_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_SETTLE,
    BK_SETUP,
    BK_DIV,
    BK_FINISH
  } back_state_t;

endpackage

// File: hw/rtl/triangle_tangent_unit_core.sv
// Top level of the triangle tangent unit: front end, queue and back end.
`timescale 1ns / 1ps

// The unit takes a triangle list one vertex per beat on the input channel
// (in_valid, in_stall, in_data) and returns one tangent beat per triangle on
// the output channel (out_valid, out_stall, out_data).
// The first two vertices of a triangle are taken without a stall and give
// no beat. The third vertex is turned into edge differences and placed in a
// queue of QUEUE_DEPTH triangles; the input stalls only on a third vertex
// while that queue is full.
// The back end works on one triangle at a time: it fetches the entry, forms
// eight products through a single 33 by 33 bit multiplier, settles the
// divisor and numerators, runs a restoring divider with the three axes in
// lock step against the shared divisor (skipped when the divisor is zero),
// and loads the result register once the output is free. It takes no new
// triangle from the queue until that result is loaded.
// A stalled output beat is held in the result register while the front end
// keeps filling the queue. Reset empties the queue, clears the corner count
// so the next vertex starts a new triangle, and drops any pending beat.

module triangle_tangent_unit_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ttu_pkg::vertex_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ttu_pkg::tangent_t out_data
);

  logic           q_push, q_full, q_pop, q_nonempty;
  ttu_pkg::diff_t q_wr_data, q_rd_data;

  // Corner capture and edge differences.
  ttu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_data   (q_wr_data),
    .q_full   (q_full)
  );

  // Decouples vertex intake from the long arithmetic of each triangle.
  ttu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wr_data),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .pop_data  (q_rd_data)
  );

  // Products, shared-divisor division, saturation and the result register.
  ttu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_nonempty),
    .q_pop     (q_pop),
    .q_data    (q_rd_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: hw/rtl/ttu_front.sv
// Front end: corner capture, corner counting and edge differences.
`timescale 1ns / 1ps

module ttu_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  ttu_pkg::vertex_t in_data,
  output logic             q_push,
  output ttu_pkg::diff_t   q_data,
  input  logic             q_full
);

  ttu_pkg::phase_t  phase, phase_next;
  ttu_pkg::vertex_t corner0, corner1;
  logic             accept;

  function automatic logic [ttu_pkg::DIFF_W-1:0] sub_ext(
    logic [ttu_pkg::COORD_W-1:0] a,
    logic [ttu_pkg::COORD_W-1:0] b
  );
    sub_ext = {a[ttu_pkg::COORD_W-1], a} - {b[ttu_pkg::COORD_W-1], b};
  endfunction

  assign in_stall = (phase == ttu_pkg::CORNER_2) && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = accept && (phase == ttu_pkg::CORNER_2);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ttu_pkg::CORNER_0;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        ttu_pkg::CORNER_0: phase_next = ttu_pkg::CORNER_1;
        ttu_pkg::CORNER_1: phase_next = ttu_pkg::CORNER_2;
        ttu_pkg::CORNER_2: phase_next = ttu_pkg::CORNER_0;
        default:           phase_next = ttu_pkg::CORNER_0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (phase == ttu_pkg::CORNER_0)) begin
      corner0 <= in_data;
    end
    if (accept && (phase == ttu_pkg::CORNER_1)) begin
      corner1 <= in_data;
    end
  end

  always_comb begin
    q_data.da1[0] = sub_ext(corner1.pos_x, corner0.pos_x);
    q_data.da1[1] = sub_ext(corner1.pos_y, corner0.pos_y);
    q_data.da1[2] = sub_ext(corner1.pos_z, corner0.pos_z);
    q_data.da2[0] = sub_ext(in_data.pos_x, corner1.pos_x);
    q_data.da2[1] = sub_ext(in_data.pos_y, corner1.pos_y);
    q_data.da2[2] = sub_ext(in_data.pos_z, corner1.pos_z);
    q_data.du1    = sub_ext(corner1.tex_u, corner0.tex_u);
    q_data.dv1    = sub_ext(corner1.tex_v, corner0.tex_v);
    q_data.du2    = sub_ext(in_data.tex_u, corner1.tex_u);
    q_data.dv2    = sub_ext(in_data.tex_v, corner1.tex_v);
  end

endmodule

// File: hw/rtl/ttu_queue.sv
// Short queue of triangle differences between the front and back ends.
`timescale 1ns / 1ps

module ttu_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ttu_pkg::diff_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output ttu_pkg::diff_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  ttu_pkg::diff_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_FULL);
  assign nonempty = (count != '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && !nonempty))
    else $error("queue read while empty");

endmodule

// File: hw/rtl/ttu_back.sv
// Back end: shared multiplier, three-lane shared-divisor divider and result register.
`timescale 1ns / 1ps

module ttu_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_pop,
  input  ttu_pkg::diff_t    q_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ttu_pkg::tangent_t out_data
);

  localparam int AXES = ttu_pkg::AXES;

  ttu_pkg::back_state_t state, state_next;
  ttu_pkg::diff_t       entry;

  logic [ttu_pkg::STEP_W-1:0]        step, pstep;
  logic                              pvalid;
  logic signed [ttu_pkg::DIFF_W-1:0] op_a, op_b;
  logic signed [ttu_pkg::PROD_W-1:0] mul_full, prod;
  logic signed [ttu_pkg::ACC_W-1:0]  acc, prod_ext;
  logic signed [ttu_pkg::ACC_W-1:0]  terms [AXES+1];

  logic                        den_zero, den_neg;
  logic [ttu_pkg::MAG_W-1:0]   den_mag;
  logic [ttu_pkg::MAG_W-1:0]   num_mag  [AXES];
  logic                        lane_ovf [AXES];
  logic                        lane_neg [AXES];

  logic                        degen;
  logic [ttu_pkg::DSH_W-1:0]   dsh;
  logic [ttu_pkg::CNT_W-1:0]   cnt;
  logic [ttu_pkg::DIVD_W-1:0]  rem [AXES];
  logic [ttu_pkg::QUO_W-1:0]   quo [AXES];
  logic                        ovf [AXES];
  logic                        neg [AXES];
  logic                        div_ge [AXES];

  logic [ttu_pkg::COORD_W-1:0] lane_val [AXES];
  logic                        lane_sat [AXES];
  ttu_pkg::tangent_t           result;
  logic                        out_free;

  function automatic logic [ttu_pkg::MAG_W-1:0] magnitude(
    logic [ttu_pkg::ACC_W-1:0] v
  );
    magnitude = v[ttu_pkg::ACC_W-1] ? ttu_pkg::MAG_W'(-v) : ttu_pkg::MAG_W'(v);
  endfunction

  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (state == ttu_pkg::BK_IDLE) && q_valid;

  // Product schedule: divisor terms first, then numerator terms per axis.
  always_comb begin
    case (step)
      3'd0:    begin op_a = $signed(entry.du1);    op_b = $signed(entry.dv2);    end
      3'd1:    begin op_a = $signed(entry.dv1);    op_b = $signed(entry.du2);    end
      3'd2:    begin op_a = $signed(entry.da1[0]); op_b = $signed(entry.dv2);    end
      3'd3:    begin op_a = $signed(entry.dv1);    op_b = $signed(entry.da2[0]); end
      3'd4:    begin op_a = $signed(entry.da1[1]); op_b = $signed(entry.dv2);    end
      3'd5:    begin op_a = $signed(entry.dv1);    op_b = $signed(entry.da2[1]); end
      3'd6:    begin op_a = $signed(entry.da1[2]); op_b = $signed(entry.dv2);    end
      default: begin op_a = $signed(entry.dv1);    op_b = $signed(entry.da2[2]); end
    endcase
  end

  assign mul_full = op_a * op_b;
  assign prod_ext = {prod[ttu_pkg::PROD_W-1], prod};

  always_comb begin
    den_zero = (terms[0] == '0);
    den_neg  = terms[0][ttu_pkg::ACC_W-1];
    den_mag  = magnitude(terms[0]);
    for (int j = 0; j < AXES; j++) begin
      num_mag[j]  = magnitude(terms[j+1]);
      lane_neg[j] = den_neg ^ terms[j+1][ttu_pkg::ACC_W-1];
      lane_ovf[j] = ttu_pkg::WIDE_W'({num_mag[j], ttu_pkg::FRAC_W'(0)})
                    >= {den_mag, ttu_pkg::QUO_W'(0)};
      div_ge[j]   = ttu_pkg::DSH_W'(rem[j]) >= dsh;
    end
  end

  always_comb begin
    for (int j = 0; j < AXES; j++) begin
      if (ovf[j]) begin
        lane_sat[j] = 1'b1;
      end else if (neg[j]) begin
        lane_sat[j] = quo[j] > ttu_pkg::QUO_NEG_MAX;
      end else begin
        lane_sat[j] = quo[j] > ttu_pkg::QUO_POS_MAX;
      end
      if (lane_sat[j]) begin
        lane_val[j] = neg[j] ? ttu_pkg::SAT_NEG : ttu_pkg::SAT_POS;
      end else if (neg[j]) begin
        lane_val[j] = ~quo[j][ttu_pkg::COORD_W-1:0] + 1'b1;
      end else begin
        lane_val[j] = quo[j][ttu_pkg::COORD_W-1:0];
      end
    end
    if (degen) begin
      result = '0;
      result.degenerate = 1'b1;
    end else begin
      result.tangent_x  = lane_val[0];
      result.tangent_y  = lane_val[1];
      result.tangent_z  = lane_val[2];
      result.degenerate = 1'b0;
      result.saturated  = lane_sat[0] | lane_sat[1] | lane_sat[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttu_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ttu_pkg::BK_IDLE:   if (q_valid) state_next = ttu_pkg::BK_MUL;
      ttu_pkg::BK_MUL:    if (step == ttu_pkg::STEP_LAST) state_next = ttu_pkg::BK_SETTLE;
      ttu_pkg::BK_SETTLE: state_next = ttu_pkg::BK_SETUP;
      ttu_pkg::BK_SETUP:  state_next = den_zero ? ttu_pkg::BK_FINISH : ttu_pkg::BK_DIV;
      ttu_pkg::BK_DIV:    if (cnt == ttu_pkg::CNT_LAST) state_next = ttu_pkg::BK_FINISH;
      ttu_pkg::BK_FINISH: if (out_free) state_next = ttu_pkg::BK_IDLE;
      default:            state_next = ttu_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pvalid <= (state == ttu_pkg::BK_MUL);
      if ((state == ttu_pkg::BK_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      entry <= q_data;
    end
    if (state == ttu_pkg::BK_IDLE) begin
      step <= '0;
    end
    if (state == ttu_pkg::BK_MUL) begin
      prod  <= mul_full;
      pstep <= step;
      step  <= step + 1'b1;
    end
    if (pvalid) begin
      if (!pstep[0]) begin
        acc <= prod_ext;
      end else begin
        terms[pstep[ttu_pkg::STEP_W-1:1]] <= acc - prod_ext;
      end
    end
    if (state == ttu_pkg::BK_SETUP) begin
      degen <= den_zero;
      dsh   <= {den_mag, (ttu_pkg::QUO_W - 1)'(0)};
      cnt   <= '0;
      for (int j = 0; j < AXES; j++) begin
        rem[j] <= {num_mag[j], ttu_pkg::FRAC_W'(0)};
        quo[j] <= '0;
        ovf[j] <= lane_ovf[j];
        neg[j] <= lane_neg[j];
      end
    end
    if (state == ttu_pkg::BK_DIV) begin
      dsh <= dsh >> 1;
      cnt <= cnt + 1'b1;
      for (int j = 0; j < AXES; j++) begin
        if (div_ge[j]) begin
          rem[j] <= rem[j] - dsh[ttu_pkg::DIVD_W-1:0];
        end
        quo[j] <= {quo[j][ttu_pkg::QUO_W-2:0], div_ge[j]};
      end
    end
    if ((state == ttu_pkg::BK_FINISH) && out_free) begin
      out_data <= result;
    end
  end

  a_degenerate_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.degenerate |->
      (out_data.tangent_x == '0) && (out_data.tangent_y == '0) &&
      (out_data.tangent_z == '0) && !out_data.saturated)
    else $error("degenerate beat carries a non-zero tangent");

  a_settle_after_last_product: assert property (@(posedge clk) disable iff (rst)
    state == ttu_pkg::BK_SETTLE |-> pvalid && (pstep == ttu_pkg::STEP_LAST))
    else $error("product schedule out of step");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ttu_pkg::BK_FINISH)
    else $error("result raised outside the finish step");

endmodule
